/* src/rmth_pkg.sv */
// Package: shared constants, types and the controller/datapath command and status structs.
`default_nettype none
package rmth_pkg;
	localparam int CAPACITY_DEF = 1024;

	typedef enum logic [2:0] {
		OP_NONE = 3'd0,
		OP_PUSH = 3'd1,
		OP_POP  = 3'd2
	} heap_op_t;

	// Command from controller to datapath
	typedef struct packed {
		logic     start;     // begin an operation
		heap_op_t op;
		logic     sel_up;    // 1: upper heap (min), 0: lower heap (max)
		logic     use_pop;   // push value taken from last pop result
		logic     clear;     // empty both heaps
		logic     load_in;   // capture input value
	} dp_cmd_t;

	// Status from datapath to controller
	typedef struct packed {
		logic busy;
		logic go_upper;      // input value belongs to upper heap
	} dp_sts_t;
endpackage
`default_nettype wire

/* src/rmth_stream_if.sv */
// Interface: valid/ready channel with a generic payload type.
`default_nettype none
interface rmth_stream_if #(parameter type payload_t = logic) ();
	logic     valid;
	logic     ready;
	payload_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

/* src/running_median_two_heaps_unit.sv */
// Top level: running median over two heaps, controller and datapath.
// Sequence: a dropped item goes straight to the output; otherwise a push, then at
// most one pop and one push to rebalance.
// Throughput: one item at a time, paced by the sift engine with one memory read
// port per heap. Next item is taken while a result waits.
// Reset: counts cleared, heap memories left unwritten; no clearing pass.
`default_nettype none
module running_median_two_heaps_unit
	import rmth_pkg::*;
#(
	parameter int CAPACITY = CAPACITY_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	rmth_stream_if.sink   in_ch,
	rmth_stream_if.source out_ch
);
	typedef enum logic [6:0] {
		C_IDLE = 7'b0000001,
		C_INS  = 7'b0000010,
		C_INSW = 7'b0000100,
		C_BAL  = 7'b0001000,
		C_BALP = 7'b0010000,
		C_BALW = 7'b0100000,
		C_OUT  = 7'b1000000
	} ctl_t;

	ctl_t st_q;
	dp_cmd_t cmd;
	dp_sts_t sts;
	logic [15:0] lc, uc;
	logic signed [31:0] lt, ut;
	logic drop_q, bal_up_q;
	logic [16:0] tot;
	assign tot = 17'(lc) + 17'(uc);

	rmth_datapath #(.SLOTS(CAPACITY / 2 + 2)) u_dp (
		.clk, .arst_n, .cmd, .in_value(in_ch.data[32:1]), .sts,
		.lower_cnt(lc), .upper_cnt(uc), .lower_top(lt), .upper_top(ut)
	);

	logic out_free;
	assign out_free = !out_ch.valid || out_ch.ready;
	assign in_ch.ready = (st_q == C_IDLE);

	// Issue commands
	always_comb begin
		cmd = '0;
		cmd.op = OP_NONE;
		case (st_q)
			C_IDLE: begin
				cmd.load_in = in_ch.valid;
				cmd.clear = in_ch.valid && in_ch.data[0];
			end
			C_INS: if (tot < 17'(CAPACITY)) begin
				cmd.start = 1'b1;
				cmd.op = OP_PUSH;
				cmd.sel_up = sts.go_upper;
			end
			C_BAL: if (lc > uc + 16'd1 || uc > lc) begin
				cmd.start = 1'b1;
				cmd.op = OP_POP;
				cmd.sel_up = (uc > lc);
			end
			C_BALP: begin
				cmd.start = 1'b1;
				cmd.op = OP_PUSH;
				cmd.sel_up = !bal_up_q;
				cmd.use_pop = 1'b1;
			end
			default: ;
		endcase
	end

	logic signed [32:0] sum;
	assign sum = 33'(lt) + 33'(ut);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= C_IDLE;
			out_ch.valid <= 1'b0;
		end else begin
			// load a new result, or drop the one taken by the receiver
			if (st_q == C_OUT && out_free) out_ch.valid <= 1'b1;
			else if (out_ch.ready) out_ch.valid <= 1'b0;
			case (st_q)
				C_IDLE: if (in_ch.valid) st_q <= C_INS;
				C_INS: begin
					drop_q <= !(tot < 17'(CAPACITY));
					st_q <= (tot < 17'(CAPACITY)) ? C_INSW : C_OUT;
				end
				C_INSW: if (!sts.busy) st_q <= C_BAL;
				C_BAL: begin
					bal_up_q <= (uc > lc);
					st_q <= cmd.start ? C_BALW : C_OUT;
				end
				C_BALW: if (!sts.busy) st_q <= C_BALP;
				C_BALP: st_q <= C_INSW;
				C_OUT: if (out_free) begin
					out_ch.data[11:1] <= tot[10:0];
					out_ch.data[0] <= drop_q;
					if (lc == 16'd0) out_ch.data[43:12] <= '0;
					else if (tot[0] || uc == 16'd0) out_ch.data[43:12] <= lt;
					else out_ch.data[43:12] <= sum[32:1];
					st_q <= C_IDLE;
				end
				default: st_q <= C_IDLE;
			endcase
		end
	end

	a_state_onehot: assert property (@(posedge clk) disable iff (!arst_n) $onehot(st_q));
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.data));
	a_count_cap: assert property (@(posedge clk) disable iff (!arst_n)
		tot <= 17'(CAPACITY));
	a_idle_balanced: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == C_IDLE |-> (lc == uc || lc == uc + 16'd1));
	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_ch.ready |-> !sts.busy);
endmodule
`default_nettype wire

/* src/rmth_datapath.sv */
// Datapath: two heap memories, counts and a sift engine for push and pop.
`default_nettype none
module rmth_datapath
	import rmth_pkg::*;
#(
	parameter int SLOTS = CAPACITY_DEF / 2 + 2
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire dp_cmd_t      cmd,
	input  wire logic [31:0]  in_value,
	output dp_sts_t           sts,
	output logic [15:0]       lower_cnt,
	output logic [15:0]       upper_cnt,
	output logic signed [31:0] lower_top,
	output logic signed [31:0] upper_top
);
	localparam int AW = $clog2(SLOTS);

	typedef enum logic [6:0] {
		S_IDLE  = 7'b0000001,
		S_PWR   = 7'b0000010,
		S_PRD   = 7'b0000100,
		S_PCMP  = 7'b0001000,
		S_DRDL  = 7'b0010000,
		S_DRDR  = 7'b0100000,
		S_DCMP  = 7'b1000000
	} sift_t;

	logic signed [31:0] mem_lo [SLOTS];
	logic signed [31:0] mem_up [SLOTS];
	logic signed [31:0] top_lo_q, top_up_q;
	logic [15:0] cnt_lo_q, cnt_up_q;
	logic signed [31:0] val_q, cur_q, pop_q, lrd_q;
	logic [AW-1:0] idx_q, par_q;
	logic [15:0] lim_q;
	logic sel_q;
	logic pop_mode_q;
	sift_t st_q;

	// Memory access control
	logic we;
	logic [AW-1:0] waddr, raddr;
	logic signed [31:0] wdata;
	logic signed [31:0] rdat_lo, rdat_up;

	always_ff @(posedge clk) begin
		if (we && !sel_q) mem_lo[waddr] <= wdata;
		if (we && sel_q) mem_up[waddr] <= wdata;
		rdat_lo <= mem_lo[raddr];
		rdat_up <= mem_up[raddr];
	end

	logic signed [31:0] rdat;
	assign rdat = sel_q ? rdat_up : rdat_lo;

	function automatic logic above(input logic up, input logic signed [31:0] a,
			input logic signed [31:0] b);
		above = up ? (a < b) : (a > b);
	endfunction

	logic [15:0] cnt_sel;
	assign cnt_sel = cmd.sel_up ? cnt_up_q : cnt_lo_q;
	logic [16:0] lidx, ridx;
	assign lidx = 17'({idx_q, 1'b1});
	assign ridx = lidx + 17'd1;

	always_comb begin
		we = 1'b0;
		waddr = idx_q;
		wdata = cur_q;
		raddr = par_q;
		case (st_q)
			S_PWR: begin
				we = 1'b1;
			end
			S_PRD: begin
				raddr = par_q;
			end
			S_PCMP: if (!pop_mode_q) begin
				// move the parent down, or drop the value into its slot
				we = 1'b1;
				if (above(sel_q, cur_q, rdat)) wdata = rdat;
			end
			S_DRDL: raddr = lidx[AW-1:0];
			S_DRDR: raddr = ridx[AW-1:0];
			S_DCMP: begin
				we = 1'b1;
				wdata = best_v;
			end
			default: ;
		endcase
	end

	logic signed [31:0] best_v;
	logic [16:0] best_i;
	always_comb begin
		best_v = cur_q;
		best_i = {{(17-AW){1'b0}}, idx_q};
		if (lidx < {1'b0, lim_q} && above(sel_q, lrd_q, best_v)) begin
			best_v = lrd_q;
			best_i = lidx;
		end
		if (ridx < {1'b0, lim_q} && above(sel_q, rdat, best_v)) begin
			best_v = rdat;
			best_i = ridx;
		end
	end

	// Sift sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
			cnt_lo_q <= '0;
			cnt_up_q <= '0;
		end else begin
			case (st_q)
				S_IDLE: begin
					if (cmd.clear) begin
						cnt_lo_q <= '0;
						cnt_up_q <= '0;
					end
					if (cmd.start && cmd.op == OP_PUSH) begin
						sel_q <= cmd.sel_up;
						cur_q <= cmd.use_pop ? pop_q : val_q;
						idx_q <= cnt_sel[AW-1:0];
						par_q <= AW'((cnt_sel - 16'd1) >> 1);
						if (cmd.sel_up) cnt_up_q <= cnt_up_q + 16'd1;
						else cnt_lo_q <= cnt_lo_q + 16'd1;
						st_q <= (cnt_sel == 16'd0) ? S_PWR : S_PRD;
					end else if (cmd.start && cmd.op == OP_POP) begin
						sel_q <= cmd.sel_up;
						pop_q <= cmd.sel_up ? top_up_q : top_lo_q;
						lim_q <= cnt_sel - 16'd1;
						par_q <= AW'(cnt_sel - 16'd1);
						idx_q <= '0;
						if (cmd.sel_up) cnt_up_q <= cnt_up_q - 16'd1;
						else cnt_lo_q <= cnt_lo_q - 16'd1;
						st_q <= S_PRD;
					end
				end
				S_PWR: begin
					if (idx_q == '0) begin
						if (sel_q) top_up_q <= cur_q; else top_lo_q <= cur_q;
					end
					st_q <= S_IDLE;
				end
				S_PRD: st_q <= S_PCMP;
				S_PCMP: begin
					if (pop_mode_q) begin
						// pop: rdat is last element, becomes root value
						cur_q <= rdat;
						if (lim_q == 16'd0) st_q <= S_IDLE;
						else st_q <= S_DRDL;
					end else if (above(sel_q, cur_q, rdat)) begin
						idx_q <= par_q;
						if (par_q == '0) begin
							if (sel_q) top_up_q <= cur_q; else top_lo_q <= cur_q;
							st_q <= S_PWR;
						end else begin
							par_q <= AW'((par_q - AW'(1)) >> 1);
							st_q <= S_PRD;
						end
					end else begin
						if (idx_q == '0) begin
							if (sel_q) top_up_q <= cur_q; else top_lo_q <= cur_q;
						end
						st_q <= S_IDLE;
					end
				end
				S_DRDL: st_q <= S_DRDR;
				S_DRDR: begin
					lrd_q <= rdat;
					st_q <= S_DCMP;
				end
				S_DCMP: begin
					if (idx_q == '0) begin
						if (sel_q) top_up_q <= best_v; else top_lo_q <= best_v;
					end
					if (best_i[AW-1:0] == idx_q) begin
						st_q <= S_IDLE;
					end else begin
						idx_q <= best_i[AW-1:0];
						st_q <= S_DRDL;
					end
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end

	// Pop mode marks the first read of a pop (fetch last element)
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) pop_mode_q <= 1'b0;
		else if (st_q == S_IDLE && cmd.start) pop_mode_q <= (cmd.op == OP_POP);
		else if (st_q == S_PCMP) pop_mode_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) val_q <= in_value;
	end

	assign sts.busy = (st_q != S_IDLE) || cmd.start;
	assign sts.go_upper = (cnt_lo_q != 16'd0) && ($signed(val_q) >= top_lo_q);
	assign lower_cnt = cnt_lo_q;
	assign upper_cnt = cnt_up_q;
	assign lower_top = top_lo_q;
	assign upper_top = top_up_q;
endmodule
`default_nettype wire

/* verif/testbench.sv */
// Testbench: directed and random checks of the running median unit.
`timescale 1ns / 100ps
`default_nettype none
module testbench
	import rmth_pkg::*;
();

	localparam int CAPACITY   = CAPACITY_DEF;
	localparam int HEAP_SLOTS = CAPACITY / 2 + 2;
	localparam int LOW_HEAP   = 0;
	localparam int HIGH_HEAP  = 1;

	typedef struct packed {
		logic signed [31:0] value;
		logic               start_new;
	} sample_t;

	typedef struct packed {
		logic signed [31:0] median_floor;
		logic [10:0]        count;
		logic               full_drop;
	} median_t;

	typedef struct {
		logic signed [31:0] value;
		bit                 start_new;
		bit                 typed;
		logic signed [31:0] median_floor;
		int                 count;
		bit                 full_drop;
	} row_t;

	logic clk;
	logic arst_n;

	rmth_stream_if #(.payload_t(sample_t)) in_ch ();
	rmth_stream_if #(.payload_t(median_t)) out_ch ();

	running_median_two_heaps_unit #(.CAPACITY(CAPACITY)) i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch.sink),
		.out_ch (out_ch.source)
	);

	// predictor state: max-heap of the lower half, min-heap of the upper half
	logic signed [31:0] heap_mem [2][HEAP_SLOTS];
	int                 heap_cnt [2];
	median_t            median_q [$];
	int                 errors;
	bit                 hold_req;

	// directed rows; typed rows carry a hand-computed median
	row_t dir_rows [16] = '{
		'{32'sd0,         1, 1, 32'sd0,          1, 0},
		'{32'h7fffffff,   0, 1, 32'sd1073741823, 2, 0},
		'{32'h80000000,   0, 1, 32'sd0,          3, 0},
		'{32'h80000000,   1, 1, 32'h80000000,    1, 0},
		'{32'h80000000,   0, 1, 32'h80000000,    2, 0},
		'{-32'sd1,        1, 1, -32'sd1,         1, 0},
		'{32'sd0,         0, 1, -32'sd1,         2, 0},
		'{32'sd0,         0, 1, 32'sd0,          3, 0},
		'{32'sd5,         1, 1, 32'sd5,          1, 0},
		'{32'sd5,         0, 1, 32'sd5,          2, 0},
		'{32'sd3,         1, 1, 32'sd3,          1, 0},
		'{-32'sd4,        0, 1, -32'sd1,         2, 0},
		'{32'h7fffffff,   0, 0, 32'sd0,          0, 0},
		'{32'h7fffffff,   0, 0, 32'sd0,          0, 0},
		'{32'sh55555555,  0, 0, 32'sd0,          0, 0},
		'{-32'sh2aaaaaab, 0, 0, 32'sd0,          0, 0}
	};

	function automatic bit ranks_above(int h, logic signed [31:0] a, logic signed [31:0] b);
		return (h == LOW_HEAP) ? (a > b) : (a < b);
	endfunction

	function automatic void heap_insert(int h, logic signed [31:0] v);
		int i;
		int p;
		logic signed [31:0] t;
		i = heap_cnt[h];
		heap_mem[h][i] = v;
		heap_cnt[h] = i + 1;
		while (i > 0) begin
			p = (i - 1) / 2;
			if (!ranks_above(h, heap_mem[h][i], heap_mem[h][p]))
				break;
			t = heap_mem[h][i];
			heap_mem[h][i] = heap_mem[h][p];
			heap_mem[h][p] = t;
			i = p;
		end
	endfunction

	function automatic logic signed [31:0] heap_extract(int h);
		int i;
		int l;
		int best;
		int n;
		logic signed [31:0] top;
		logic signed [31:0] t;
		top = heap_mem[h][0];
		n = heap_cnt[h] - 1;
		heap_cnt[h] = n;
		heap_mem[h][0] = heap_mem[h][n];
		i = 0;
		forever begin
			l = 2 * i + 1;
			best = i;
			if (l < n && ranks_above(h, heap_mem[h][l], heap_mem[h][best]))
				best = l;
			if (l + 1 < n && ranks_above(h, heap_mem[h][l + 1], heap_mem[h][best]))
				best = l + 1;
			if (best == i)
				break;
			t = heap_mem[h][i];
			heap_mem[h][i] = heap_mem[h][best];
			heap_mem[h][best] = t;
			i = best;
		end
		return top;
	endfunction

	// add one sample to the running set and return the resulting median
	function automatic median_t add_sample(sample_t s);
		median_t r;
		logic signed [63:0] sum;
		int total;
		r.full_drop = 1'b0;
		if (s.start_new) begin
			heap_cnt[LOW_HEAP] = 0;
			heap_cnt[HIGH_HEAP] = 0;
		end
		if (heap_cnt[LOW_HEAP] + heap_cnt[HIGH_HEAP] >= CAPACITY) begin
			r.full_drop = 1'b1;
		end else begin
			if (heap_cnt[LOW_HEAP] > 0 && s.value >= heap_mem[LOW_HEAP][0])
				heap_insert(HIGH_HEAP, s.value);
			else
				heap_insert(LOW_HEAP, s.value);
			if (heap_cnt[LOW_HEAP] > heap_cnt[HIGH_HEAP] + 1)
				heap_insert(HIGH_HEAP, heap_extract(LOW_HEAP));
			else if (heap_cnt[HIGH_HEAP] > heap_cnt[LOW_HEAP])
				heap_insert(LOW_HEAP, heap_extract(HIGH_HEAP));
		end
		total = heap_cnt[LOW_HEAP] + heap_cnt[HIGH_HEAP];
		r.count = total[10:0];
		if (total == 0 || heap_cnt[LOW_HEAP] == 0) begin
			r.median_floor = '0;
		end else if (total % 2 == 1 || heap_cnt[HIGH_HEAP] == 0) begin
			r.median_floor = heap_mem[LOW_HEAP][0];
		end else begin
			sum = 64'(heap_mem[LOW_HEAP][0]) + 64'(heap_mem[HIGH_HEAP][0]);
			r.median_floor = 32'(sum >>> 1);
		end
		return r;
	endfunction

	function automatic int pick_gap();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 65)
			return 0;
		if (roll < 95)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function automatic logic signed [31:0] pick_value();
		case ($urandom_range(0, 5))
			0: return $urandom_range(0, 20) - 10;
			1: return 32'h7fffffff - $urandom_range(0, 3);
			2: return 32'h80000000 + $urandom_range(0, 3);
			3: return $urandom_range(0, 1000);
			default: return $urandom;
		endcase
	endfunction

	// offer one item, hold it until taken, then idle for a random gap
	task automatic offer_sample(sample_t s, bit typed, median_t typed_res);
		median_t pred;
		int gap;
		in_ch.valid <= 1'b1;
		in_ch.data  <= s;
		do
			@(posedge clk);
		while (!in_ch.ready);
		pred = add_sample(s);
		median_q.push_back(typed ? typed_res : pred);
		gap = pick_gap();
		if (gap > 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#60_000_000;
		$display("simulation failed");
		$finish;
	end

	// receiver: random stalls, one long hold-off on request
	initial begin
		int gap;
		out_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			out_ch.ready <= 1'b1;
			repeat ($urandom_range(0, 4) == 0 ? $urandom_range(20, 60) : $urandom_range(1, 6))
				@(posedge clk);
			gap = pick_gap();
			if (hold_req) begin
				hold_req = 1'b0;
				out_ch.ready <= 1'b0;
				repeat (400) @(posedge clk);
			end else if (gap > 0) begin
				out_ch.ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	end

	// compare each delivered median with the oldest expected one
	always @(posedge clk) begin
		median_t want;
		median_t got;
		if (out_ch.valid && out_ch.ready) begin
			got = out_ch.data;
			if (median_q.size() == 0) begin
				$error("unexpected item: median_floor %0d count %0d", got.median_floor,
				       got.count);
				errors++;
			end else begin
				want = median_q.pop_front();
				if (got.median_floor !== want.median_floor) begin
					$error("median_floor: expected %0d, got %0d", want.median_floor,
					       got.median_floor);
					errors++;
				end
				if (got.count !== want.count) begin
					$error("count: expected %0d, got %0d", want.count, got.count);
					errors++;
				end
				if (got.full_drop !== want.full_drop) begin
					$error("full_drop: expected %0b, got %0b", want.full_drop, got.full_drop);
					errors++;
				end
			end
		end
	end

	initial begin
		sample_t s;
		median_t typed_res;
		int seq_len;
		int done_items;
		bit hold_sent;
		errors = 0;
		hold_req = 1'b0;
		hold_sent = 1'b0;
		heap_cnt[LOW_HEAP] = 0;
		heap_cnt[HIGH_HEAP] = 0;
		in_ch.valid = 1'b0;
		in_ch.data  = '0;
		arst_n = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// walk the directed table
		foreach (dir_rows[k]) begin
			s.value = dir_rows[k].value;
			s.start_new = dir_rows[k].start_new;
			typed_res.median_floor = dir_rows[k].median_floor;
			typed_res.count = dir_rows[k].count[10:0];
			typed_res.full_drop = dir_rows[k].full_drop;
			offer_sample(s, dir_rows[k].typed, typed_res);
		end

		// pause the sender until every median has come back
		in_ch.valid <= 1'b0;
		wait (median_q.size() == 0);
		@(posedge clk);

		// random runs: each opens a fresh set, most short
		done_items = 0;
		while (done_items < 100) begin
			if (done_items >= 40 && !hold_sent) begin
				hold_req = 1'b1;
				hold_sent = 1'b1;
			end
			seq_len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40)
			                                       : $urandom_range(1, 15);
			for (int j = 0; j < seq_len; j++) begin
				s.value = pick_value();
				s.start_new = (j == 0) ? 1'b1 : ($urandom_range(0, 49) == 0);
				offer_sample(s, 1'b0, typed_res);
			end
			done_items += seq_len;
		end

		// fill the store and keep pushing so samples are dropped
		for (int j = 0; j < CAPACITY + 12; j++) begin
			s.value = pick_value();
			s.start_new = (j == 0);
			offer_sample(s, 1'b0, typed_res);
		end
		s.value = 32'sd7;
		s.start_new = 1'b1;
		offer_sample(s, 1'b0, typed_res);

		in_ch.valid <= 1'b0;
		wait (median_q.size() == 0);
		repeat (100) @(posedge clk);
		if (errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end
endmodule
`default_nettype wire
